@@ rtl/htwd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htwd_pkg: shared definitions for the huffman tree walk decoder
// Field widths, request codes and default sizes shared by the walker, top and bench.
// ----------------------------------------------------------------------------
package htwd_pkg;

  // fixed field widths
  localparam int IDX_BITS      = 9;
  localparam int SYM_PORT_BITS = 8;
  localparam int BYTE_BITS     = 8;
  localparam int CNT_BITS      = 4;
  localparam int OP_BITS       = 2;

  // default sizes
  localparam int NODE_COUNT_DEF  = 512;
  localparam int SYMBOL_BITS_DEF = 8;

  // request codes, the fourth code does nothing
  typedef enum logic [OP_BITS-1:0] {
    OP_WRITE   = 2'd0,
    OP_DECODE  = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

endpackage

@@ rtl/htwd_node_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htwd_node_ram: node table storage
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module htwd_node_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 27,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             re,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/htwd_walker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htwd_walker: bit serial tree walk sequencer
// Takes a code byte only when idle, shifts it out bit by bit and reads one
// node per bit, holding each symbol back until it is known if it is last.
// ----------------------------------------------------------------------------
module htwd_walker #(
  parameter int NODE_COUNT  = 512,
  parameter int SYMBOL_BITS = 8,
  localparam int AW = $clog2(NODE_COUNT),
  localparam int EW = 1 + SYMBOL_BITS + 2 * htwd_pkg::IDX_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              restart,
  input  logic [htwd_pkg::BYTE_BITS-1:0]    data_byte,
  input  logic [htwd_pkg::CNT_BITS-1:0]     bit_count,
  input  logic [htwd_pkg::IDX_BITS-1:0]     root_index,
  output logic                              rd_en,
  output logic [AW-1:0]                     rd_addr,
  input  logic [EW-1:0]                     rd_data,
  output logic                              busy,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [htwd_pkg::SYM_PORT_BITS-1:0] symbol,
  output logic                              last
);
  import htwd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FLUSH} state_t;

  state_t                   state, state_next;
  logic [IDX_BITS-1:0]      walk_pos, walk_pos_next;
  logic [BYTE_BITS-1:0]     shift, shift_next;
  logic [CNT_BITS-1:0]      bits_left, bits_left_next;
  logic                     reached, reached_next;
  logic                     rd_ok, rd_ok_next;
  logic                     pend_valid, pend_valid_next;
  logic [SYM_PORT_BITS-1:0] pend_sym, pend_sym_next;
  logic                     out_valid_next;
  logic [SYM_PORT_BITS-1:0] symbol_next;
  logic                     last_next;

  logic [IDX_BITS-1:0]      rd_idx;
  logic                     push, push_last, can_push;
  logic [CNT_BITS-1:0]      cnt_sat;
  logic                     e_leaf;
  logic [SYMBOL_BITS-1:0]   e_sym;
  logic [IDX_BITS-1:0]      e_left, e_right, next_idx;

  // entry fields, an index beyond the table reads as an empty node
  assign e_right  = rd_ok ? rd_data[IDX_BITS-1:0] : '0;
  assign e_left   = rd_ok ? rd_data[2*IDX_BITS-1:IDX_BITS] : '0;
  assign e_sym    = rd_ok ? rd_data[2*IDX_BITS+SYMBOL_BITS-1:2*IDX_BITS] : '0;
  assign e_leaf   = rd_ok & rd_data[EW-1];
  assign next_idx = shift[BYTE_BITS-1] ? e_right : e_left;

  assign cnt_sat  = (bit_count > CNT_BITS'(BYTE_BITS)) ? CNT_BITS'(BYTE_BITS) : bit_count;
  assign can_push = !out_valid || !out_stall;
  assign rd_addr  = AW'(rd_idx);
  assign busy     = (state != S_IDLE);

  // walk sequencing
  always_comb begin
    state_next      = state;
    walk_pos_next   = walk_pos;
    shift_next      = shift;
    bits_left_next  = bits_left;
    reached_next    = reached;
    pend_valid_next = pend_valid;
    pend_sym_next   = pend_sym;
    rd_en           = 1'b0;
    rd_idx          = walk_pos;
    push            = 1'b0;
    push_last       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (restart) begin
          walk_pos_next = root_index;
        end
        if (start) begin
          rd_en          = 1'b1;
          shift_next     = data_byte;
          bits_left_next = cnt_sat;
          reached_next   = 1'b0;
          state_next     = S_WALK;
        end
      end
      S_WALK: begin
        priority if (reached && e_leaf) begin
          // a leaf ends a code; the previous symbol is now known not to be last
          if (!pend_valid || can_push) begin
            push            = pend_valid;
            pend_valid_next = 1'b1;
            pend_sym_next   = SYM_PORT_BITS'(e_sym);
            walk_pos_next   = root_index;
            reached_next    = 1'b0;
            if (bits_left != '0) begin
              rd_en  = 1'b1;
              rd_idx = root_index;
            end else begin
              state_next = S_FLUSH;
            end
          end
        end else if (bits_left != '0) begin
          // one code bit, one node read
          rd_en          = 1'b1;
          rd_idx         = next_idx;
          walk_pos_next  = next_idx;
          shift_next     = {shift[BYTE_BITS-2:0], 1'b0};
          bits_left_next = bits_left - 1'b1;
          reached_next   = 1'b1;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (can_push) begin
          push            = 1'b1;
          push_last       = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // range flag follows the read
  assign rd_ok_next = rd_en ? (32'(rd_idx) < NODE_COUNT) : rd_ok;

  // output register
  assign out_valid_next = push | (out_valid & out_stall);
  assign symbol_next    = push ? pend_sym : symbol;
  assign last_next      = push ? push_last : last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      walk_pos   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      reached    <= 1'b0;
    end else begin
      state      <= state_next;
      walk_pos   <= walk_pos_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
      reached    <= reached_next;
    end
    shift     <= shift_next;
    bits_left <= bits_left_next;
    rd_ok     <= rd_ok_next;
    pend_sym  <= pend_sym_next;
    symbol    <= symbol_next;
    last      <= last_next;
  end

endmodule

@@ rtl/huffman_tree_walk_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_top: huffman decoder walking a node table
// Node writes, walk restarts and code bytes arrive on one request channel;
// decoded symbols leave on the result channel with a last flag per byte.
// ----------------------------------------------------------------------------
// A decode request is walked code bit by code bit, each bit being one read
// of the node table. Each symbol is held until the next one is found or the
// byte ends, so that its last flag is known. New requests are taken once the
// previous byte has handed its final symbol to the output register.
// Unwritten table entries read as undefined.
module huffman_tree_walk_decoder_top #(
  parameter int NODE_COUNT  = htwd_pkg::NODE_COUNT_DEF,
  parameter int SYMBOL_BITS = htwd_pkg::SYMBOL_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [htwd_pkg::IDX_BITS-1:0]      cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [htwd_pkg::OP_BITS-1:0]       op,
  input  logic [htwd_pkg::IDX_BITS-1:0]      node_index,
  input  logic                               node_is_leaf,
  input  logic [htwd_pkg::SYM_PORT_BITS-1:0] node_symbol,
  input  logic [htwd_pkg::IDX_BITS-1:0]      left_child,
  input  logic [htwd_pkg::IDX_BITS-1:0]      right_child,
  input  logic [htwd_pkg::BYTE_BITS-1:0]     data_byte,
  input  logic [htwd_pkg::CNT_BITS-1:0]      bit_count,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [htwd_pkg::SYM_PORT_BITS-1:0] symbol,
  output logic                               last
);
  import htwd_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);
  localparam int EW = 1 + SYMBOL_BITS + 2 * IDX_BITS;

  logic [IDX_BITS-1:0] root_index;
  logic                in_accept, busy;
  logic                ram_we, rd_en;
  logic [AW-1:0]       rd_addr;
  logic [EW-1:0]       wr_data, rd_data;
  logic                start, restart;

  // root register
  always_ff @(posedge clk) begin
    if (rst) begin
      root_index <= '0;
    end else if (cfg_we) begin
      root_index <= cfg_wdata;
    end
  end

  // request decode
  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;
  assign ram_we    = in_accept && (op == OP_WRITE) && (32'(node_index) < NODE_COUNT);
  assign start     = in_accept && (op == OP_DECODE) && (bit_count != '0);
  assign restart   = in_accept && (op == OP_RESTART);
  assign wr_data   = {node_is_leaf, SYMBOL_BITS'(node_symbol), left_child, right_child};

  htwd_node_ram #(
    .DEPTH (NODE_COUNT),
    .WIDTH (EW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (AW'(node_index)),
    .wr_data (wr_data),
    .re      (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  htwd_walker #(
    .NODE_COUNT  (NODE_COUNT),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .restart    (restart),
    .data_byte  (data_byte),
    .bit_count  (bit_count),
    .root_index (root_index),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .symbol     (symbol),
    .last       (last)
  );

  // table writes never land in the middle of a walk
  a_write_idle: assert property (@(posedge clk) disable iff (rst) ram_we |-> !busy)
    else $error("node write while walking");

  // results only come from a walk
  a_out_from_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy))
    else $error("result without a walk");

  // a decode request with bits starts the walker
  a_decode_starts: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("decode request not started");

endmodule

@@ verif/tb_huffman_tree_walk_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_tree_walk_decoder_top: self-checking bench for the tree walk decoder
// Builds random code trees in the node table, moves the root register and
// streams code bytes with random idling on both channels. A shadow copy of
// the table is walked bit by bit to predict every symbol and its last flag.
// ----------------------------------------------------------------------------
module tb_huffman_tree_walk_decoder_top;
  import htwd_pkg::*;

  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam int TABLE_SIZE    = 1 << IDX_BITS;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;

  typedef struct {
    logic [OP_BITS-1:0]       op;
    logic [IDX_BITS-1:0]      idx;
    logic                     is_leaf;
    logic [SYM_PORT_BITS-1:0] sym;
    logic [IDX_BITS-1:0]      lchild;
    logic [IDX_BITS-1:0]      rchild;
    logic [BYTE_BITS-1:0]     data;
    logic [CNT_BITS-1:0]      cnt;
  } walk_req_t;

  typedef struct {
    logic [SYM_PORT_BITS-1:0] symbol;
    logic                     last;
  } sym_out_t;

  // block ports
  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     cfg_we       = 1'b0;
  logic [IDX_BITS-1:0]      cfg_wdata    = '0;
  logic                     in_valid     = 1'b0;
  logic                     in_stall;
  logic [OP_BITS-1:0]       op           = '0;
  logic [IDX_BITS-1:0]      node_index   = '0;
  logic                     node_is_leaf = 1'b0;
  logic [SYM_PORT_BITS-1:0] node_symbol  = '0;
  logic [IDX_BITS-1:0]      left_child   = '0;
  logic [IDX_BITS-1:0]      right_child  = '0;
  logic [BYTE_BITS-1:0]     data_byte    = '0;
  logic [CNT_BITS-1:0]      bit_count    = '0;
  logic                     out_valid;
  logic                     out_stall    = 1'b0;
  logic [SYM_PORT_BITS-1:0] symbol;
  logic                     last;

  // shadow node table and walk state
  logic                     nt_leaf  [TABLE_SIZE];
  logic [SYM_PORT_BITS-1:0] nt_sym   [TABLE_SIZE];
  logic [IDX_BITS-1:0]      nt_left  [TABLE_SIZE];
  logic [IDX_BITS-1:0]      nt_right [TABLE_SIZE];
  bit                       nt_written [TABLE_SIZE];
  logic [IDX_BITS-1:0]      written_ids[$];
  logic [IDX_BITS-1:0]      root_sel = '0;
  logic [IDX_BITS-1:0]      walk_at  = '0;
  sym_out_t                 symbols_due[$];

  // tree building scratch
  bit                       tree_taken [TABLE_SIZE];
  logic [IDX_BITS-1:0]      tree_tops[$];

  int fail_count   = 0;
  int quiet_cycles = 0;
  bit tx_idle_on   = 1'b1;
  bit rx_idle_on   = 1'b1;
  bit rx_hold_req  = 1'b0;

  huffman_tree_walk_decoder_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .node_index   (node_index),
    .node_is_leaf (node_is_leaf),
    .node_symbol  (node_symbol),
    .left_child   (left_child),
    .right_child  (right_child),
    .data_byte    (data_byte),
    .bit_count    (bit_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .symbol       (symbol),
    .last         (last)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow table walk, queues the symbols a request should yield
  function automatic void decode_walk(input walk_req_t r);
    sym_out_t            found[$];
    logic [IDX_BITS-1:0] nxt;
    int                  steps;
    int                  i;
    case (r.op)
      OP_WRITE: begin
        nt_leaf[r.idx]  = r.is_leaf;
        nt_sym[r.idx]   = r.sym;
        nt_left[r.idx]  = r.lchild;
        nt_right[r.idx] = r.rchild;
        if (!nt_written[r.idx]) begin
          nt_written[r.idx] = 1'b1;
          written_ids.push_back(r.idx);
        end
      end
      OP_RESTART: walk_at = root_sel;
      OP_DECODE: begin
        // counts above a byte saturate
        steps = (r.cnt > BYTE_BITS) ? BYTE_BITS : int'(r.cnt);
        for (i = 0; i < steps; i++) begin
          nxt = r.data[BYTE_BITS-1-i] ? nt_right[walk_at] : nt_left[walk_at];
          if (nt_leaf[nxt]) begin
            found.push_back('{symbol: nt_sym[nxt], last: 1'b0});
            walk_at = root_sel;
          end else begin
            walk_at = nxt;
          end
        end
        if (found.size() > 0) found[found.size()-1].last = 1'b1;
        foreach (found[k]) symbols_due.push_back(found[k]);
      end
      default: ;
    endcase
  endfunction

  // request with every field random
  function automatic walk_req_t rand_req(input logic [OP_BITS-1:0] code);
    walk_req_t r;
    r.op      = code;
    r.idx     = IDX_BITS'($urandom_range(0, TABLE_SIZE-1));
    r.is_leaf = 1'($urandom_range(0, 1));
    r.sym     = SYM_PORT_BITS'($urandom_range(0, 255));
    r.lchild  = IDX_BITS'($urandom_range(0, TABLE_SIZE-1));
    r.rchild  = IDX_BITS'($urandom_range(0, TABLE_SIZE-1));
    r.data    = BYTE_BITS'($urandom_range(0, 255));
    r.cnt     = CNT_BITS'($urandom_range(1, BYTE_BITS));
    return r;
  endfunction

  function automatic logic [IDX_BITS-1:0] pick_written();
    return written_ids[$urandom_range(0, written_ids.size()-1)];
  endfunction

  function automatic logic [IDX_BITS-1:0] fresh_index();
    logic [IDX_BITS-1:0] v;
    do v = IDX_BITS'($urandom_range(0, TABLE_SIZE-1)); while (tree_taken[v]);
    tree_taken[v] = 1'b1;
    return v;
  endfunction

  function automatic logic [IDX_BITS-1:0] pull_top();
    logic [IDX_BITS-1:0] v;
    int                  j;
    j = $urandom_range(0, tree_tops.size()-1);
    v = tree_tops[j];
    tree_tops.delete(j);
    return v;
  endfunction

  // offer one request, with random idle cycles ahead of it while idling is on
  task automatic push_request(input walk_req_t r);
    while (tx_idle_on && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= r.op;
    node_index   <= r.idx;
    node_is_leaf <= r.is_leaf;
    node_symbol  <= r.sym;
    left_child   <= r.lchild;
    right_child  <= r.rchild;
    data_byte    <= r.data;
    bit_count    <= r.cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_walk(r);
  endtask

  task automatic send_decode(input logic [BYTE_BITS-1:0] data, input logic [CNT_BITS-1:0] cnt);
    walk_req_t r;
    r      = rand_req(OP_DECODE);
    r.data = data;
    r.cnt  = cnt;
    push_request(r);
  endtask

  task automatic send_code(input logic [OP_BITS-1:0] code);
    push_request(rand_req(code));
  endtask

  task automatic write_node(input logic [IDX_BITS-1:0] idx, input logic is_leaf,
                            input logic [IDX_BITS-1:0] lc, input logic [IDX_BITS-1:0] rc);
    walk_req_t r;
    r         = rand_req(OP_WRITE);
    r.idx     = idx;
    r.is_leaf = is_leaf;
    r.lchild  = lc;
    r.rchild  = rc;
    push_request(r);
  endtask

  // write a random full tree, leaves first so no entry points at an unwritten one
  task automatic load_tree(input int leaves, input int fixed_root,
                           output logic [IDX_BITS-1:0] top);
    walk_req_t           r;
    logic [IDX_BITS-1:0] id;
    int                  k;
    foreach (tree_taken[n]) tree_taken[n] = 1'b0;
    tree_tops.delete();
    if (fixed_root >= 0) tree_taken[fixed_root] = 1'b1;
    for (k = 0; k < leaves; k++) begin
      id = (leaves == 1 && fixed_root >= 0) ? IDX_BITS'(fixed_root) : fresh_index();
      r         = rand_req(OP_WRITE);
      r.idx     = id;
      r.is_leaf = 1'b1;
      r.lchild  = (written_ids.size() == 0) ? id : pick_written();
      r.rchild  = (written_ids.size() == 0) ? id : pick_written();
      push_request(r);
      tree_tops.push_back(id);
    end
    // pair subtrees until one root is left
    while (tree_tops.size() > 1) begin
      r         = rand_req(OP_WRITE);
      r.is_leaf = 1'b0;
      r.lchild  = pull_top();
      r.rchild  = pull_top();
      r.idx     = (tree_tops.size() == 0 && fixed_root >= 0) ? IDX_BITS'(fixed_root)
                                                              : fresh_index();
      push_request(r);
      tree_tops.push_back(r.idx);
    end
    top = tree_tops[0];
  endtask

  // sender holds back until every symbol is in, then lets a byte finish
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (symbols_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_root(input logic [IDX_BITS-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    root_sel  = v;
  endtask

  // tree rooted at the reset root, count extremes and the unused code
  task automatic test_reset_tree();
    logic [IDX_BITS-1:0] top;
    load_tree(4, 0, top);
    send_decode(8'h00, 4'd8);
    send_decode(8'hFF, 4'd8);
    send_decode(8'hA5, 4'd1);
    send_decode(8'h5A, 4'd0);
    send_decode(8'h3C, 4'd15);
    send_decode(8'hC3, 4'd9);
    send_code(OP_UNUSED);
    send_code(OP_RESTART);
    send_decode(BYTE_BITS'($urandom_range(0, 255)), 4'd8);
  endtask

  // root register moves, walk stays put until a restart
  task automatic test_root_move();
    logic [IDX_BITS-1:0] top;
    load_tree(3, TABLE_SIZE-1, top);
    send_decode(8'h96, 4'd8);
    set_root(top);
    send_decode(8'h69, 4'd8);
    send_code(OP_RESTART);
    send_decode(8'hF0, 4'd8);
    send_decode(8'h0F, 4'd7);
  endtask

  // leaf as root, pointing at itself: one symbol per bit
  task automatic test_leaf_root();
    logic [IDX_BITS-1:0] lf;
    lf = IDX_BITS'($urandom_range(1, TABLE_SIZE-2));
    write_node(lf, 1'b1, lf, lf);
    set_root(lf);
    send_code(OP_RESTART);
    send_decode(8'hC3, 4'd8);
    send_decode(8'h81, 4'd12);
  endtask

  // fresh tree per phase, then a random mix of requests
  task automatic test_random_mix();
    logic [IDX_BITS-1:0] top;
    logic [CNT_BITS-1:0] cnt;
    int                  ph;
    int                  k;
    int                  pick;
    for (ph = 0; ph < 5; ph++) begin
      load_tree($urandom_range(2, 9), (ph == 0) ? 0 : (ph == 1) ? TABLE_SIZE-1 : -1, top);
      set_root(top);
      // one phase runs flat out on both sides
      tx_idle_on = (ph != 2);
      rx_idle_on = (ph != 2);
      send_code(OP_RESTART);
      for (k = 0; k < 14; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
          cnt = ($urandom_range(0, 19) == 0) ? CNT_BITS'($urandom_range(0, 15))
                                             : CNT_BITS'($urandom_range(1, 8));
          send_decode(BYTE_BITS'($urandom_range(0, 255)), cnt);
        end else if (pick < 82) begin
          send_code(OP_RESTART);
        end else if (pick < 88) begin
          send_code(OP_UNUSED);
        end else begin
          write_node(IDX_BITS'($urandom_range(0, TABLE_SIZE-1)), 1'($urandom_range(0, 1)),
                     pick_written(), pick_written());
        end
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // receiver holds off long while full bytes keep coming
  task automatic test_backpressure();
    logic [IDX_BITS-1:0] top;
    load_tree(2, -1, top);
    set_root(top);
    send_code(OP_RESTART);
    rx_hold_req = 1'b1;
    repeat (14) send_decode(BYTE_BITS'($urandom_range(0, 255)), 4'd8);
    wait_drained();
  endtask

  // result side stall pattern
  initial begin : rx_pacing
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      out_stall <= rx_idle_on && ($urandom_range(0, 99) < 19);
    end
  end

  // compare each accepted symbol with the oldest prediction
  always @(posedge clk) begin : result_check
    sym_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (symbols_due.size() == 0) begin
        $error("symbol %0h arrived with nothing pending", symbol);
        fail_count++;
      end else begin
        want = symbols_due.pop_front();
        if (symbol !== want.symbol) begin
          $error("symbol: expected %0h, got %0h", want.symbol, symbol);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          fail_count++;
        end
      end
    end
  end

  // stop a run that stops moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_huffman_tree_walk_decoder_top: done, errors");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // test sequence
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_tree();
    test_root_move();
    test_leaf_root();
    test_random_mix();
    test_backpressure();
    wait_drained();
    if (fail_count == 0) begin
      $display("tb_huffman_tree_walk_decoder_top: done, clean");
    end else begin
      $display("tb_huffman_tree_walk_decoder_top: done, errors");
    end
    $finish;
  end

endmodule

@@ huffman_tree_walk_decoder_top.f @@
rtl/htwd_pkg.sv
rtl/htwd_node_ram.sv
rtl/htwd_walker.sv
rtl/huffman_tree_walk_decoder_top.sv
verif/tb_huffman_tree_walk_decoder_top.sv
